>>> sv/tlbcr_pkg.sv
package tlbcr_pkg;

    localparam int VIRT_PAGE_W = 20;
    localparam int FRAME_W     = 20;
    localparam int SLOT_W      = 4;
    localparam int HIT_TOTAL_W = 32;

    // Prefix flags rippled from the lowest cell upward.
    typedef struct packed {
        logic hit_seen;
        logic inv_seen;
        logic unu_seen;
    } tlbcr_flag_t;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic capture;
        logic apply;
        logic is_write;
        logic any_hit;
        logic any_inv;
        logic any_unu;
    } tlbcr_ctrl_t;

endpackage

>>> sv/tlbcr_if.sv
interface tlbcr_req_if;
    logic                             valid;
    logic                             ready;
    logic [tlbcr_pkg::VIRT_PAGE_W-1:0] virt_page;
    logic                             is_write;
    logic [tlbcr_pkg::FRAME_W-1:0]     walk_frame;

    modport source (output valid, output virt_page, output is_write, output walk_frame,
                    input ready);
    modport sink   (input valid, input virt_page, input is_write, input walk_frame,
                    output ready);
endinterface

interface tlbcr_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [tlbcr_pkg::FRAME_W-1:0] frame;
    logic                         hit;
    logic [tlbcr_pkg::SLOT_W-1:0]  slot;

    modport source (output valid, output frame, output hit, output slot, input ready);
    modport sink   (input valid, input frame, input hit, input slot, output ready);
endinterface

>>> sv/tlb_lookup_clock_replace_unit.sv
// Fully associative TLB with clock replacement.
// The req channel carries one lookup word: virtual page, write flag and the
// frame that the page-table walk supplies for a miss. The rsp channel returns
// one word per lookup: the frame, a hit flag and the slot that hit or was
// filled. Both channels move a word when valid and ready are high together.
// Each entry lives in one cell of a row; cells compare in parallel and pass
// priority flags and the selected frame and slot up the row to their neighbor.
// A lookup first registers every cell's compare; then, in its resolve state,
// it resolves the row, updates the marks and loads the output register. The
// result is visible the cycle after that; a new word is taken only while no
// lookup is in progress. Reset clears the valid, used and dirty marks, the hit
// counter and the output valid bit; entry contents stay unknown until filled.
// While rsp is stalled the output register holds its word; one further
// lookup may be accepted and then waits in its resolve cycle.
module tlb_lookup_clock_replace_unit #(
    parameter int ENTRIES    = 16,
    parameter int PAGE_BITS  = 20,
    parameter int FRAME_BITS = 20
) (
    input  logic      clk,
    input  logic      rst_n,
    tlbcr_req_if.sink req,
    tlbcr_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(ENTRIES);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOOK = 1'b1;

    logic                                 state_reg;
    logic [PAGE_BITS-1:0]                 page_reg;
    logic                                 wr_reg;
    logic [FRAME_BITS-1:0]                walk_reg;
    logic                                 out_valid_reg;
    logic [tlbcr_pkg::FRAME_W-1:0]        out_frame_reg;
    logic                                 out_hit_reg;
    logic [tlbcr_pkg::SLOT_W-1:0]         out_slot_reg;
    logic [tlbcr_pkg::HIT_TOTAL_W-1:0]    hit_total_reg;

    logic                                 accept;
    logic                                 apply;
    logic [PAGE_BITS-1:0]                 in_page;
    tlbcr_pkg::tlbcr_ctrl_t               ctrl;
    tlbcr_pkg::tlbcr_flag_t               flag_chain [ENTRIES+1];
    logic [FRAME_BITS-1:0]                frame_chain [ENTRIES+1];
    logic [IDX_W-1:0]                     slot_chain [ENTRIES+1];
    logic [FRAME_BITS-1:0]                result_frame;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign apply     = (state_reg == ST_LOOK) && (!out_valid_reg || rsp.ready);
    assign in_page   = PAGE_BITS'(req.virt_page);

    assign ctrl.capture  = accept;
    assign ctrl.apply    = apply;
    assign ctrl.is_write = wr_reg;
    assign ctrl.any_hit  = flag_chain[ENTRIES].hit_seen;
    assign ctrl.any_inv  = flag_chain[ENTRIES].inv_seen;
    assign ctrl.any_unu  = flag_chain[ENTRIES].unu_seen;

    assign flag_chain[0]  = '0;
    assign frame_chain[0] = '0;
    assign slot_chain[0]  = '0;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        tlbcr_cell #(
            .IDX        (g),
            .IDX_W      (IDX_W),
            .PAGE_BITS  (PAGE_BITS),
            .FRAME_BITS (FRAME_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .look_page  (in_page),
            .fill_page  (page_reg),
            .fill_frame (walk_reg),
            .flag_in    (flag_chain[g]),
            .flag_out   (flag_chain[g+1]),
            .frame_in   (frame_chain[g]),
            .frame_out  (frame_chain[g+1]),
            .slot_in    (slot_chain[g]),
            .slot_out   (slot_chain[g+1])
        );
    end

    assign result_frame = ctrl.any_hit ? frame_chain[ENTRIES] : walk_reg;

    assign rsp.valid = out_valid_reg;
    assign rsp.frame = out_frame_reg;
    assign rsp.hit   = out_hit_reg;
    assign rsp.slot  = out_slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            hit_total_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK:
                begin
                    if (apply)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (apply)
            begin
                out_valid_reg <= 1'b1;
                if (ctrl.any_hit)
                begin
                    hit_total_reg <= hit_total_reg + 1'b1;
                end
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg <= in_page;
            wr_reg   <= req.is_write;
            walk_reg <= FRAME_BITS'(req.walk_frame);
        end
        if (apply)
        begin
            out_frame_reg <= tlbcr_pkg::FRAME_W'(result_frame);
            out_hit_reg   <= ctrl.any_hit;
            out_slot_reg  <= tlbcr_pkg::SLOT_W'(slot_chain[ENTRIES]);
        end
    end

endmodule

>>> sv/tlbcr_cell.sv
module tlbcr_cell #(
    parameter int IDX        = 0,
    parameter int IDX_W      = 4,
    parameter int PAGE_BITS  = 20,
    parameter int FRAME_BITS = 20
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tlbcr_pkg::tlbcr_ctrl_t ctrl,
    input  logic [PAGE_BITS-1:0]   look_page,
    input  logic [PAGE_BITS-1:0]   fill_page,
    input  logic [FRAME_BITS-1:0]  fill_frame,
    input  tlbcr_pkg::tlbcr_flag_t flag_in,
    output tlbcr_pkg::tlbcr_flag_t flag_out,
    input  logic [FRAME_BITS-1:0]  frame_in,
    output logic [FRAME_BITS-1:0]  frame_out,
    input  logic [IDX_W-1:0]       slot_in,
    output logic [IDX_W-1:0]       slot_out
);

    logic [PAGE_BITS-1:0]  page_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic                  valid_reg;
    logic                  used_reg;
    logic                  dirty_reg;
    logic                  match_reg;
    logic                  my_hit;
    logic                  fill;
    logic                  clear;

    // Only the lowest matching cell claims the hit.
    assign my_hit = match_reg && !flag_in.hit_seen;

    assign flag_out.hit_seen = flag_in.hit_seen | match_reg;
    assign flag_out.inv_seen = flag_in.inv_seen | !valid_reg;
    assign flag_out.unu_seen = flag_in.unu_seen | !used_reg;

    // Victim choice: lowest invalid slot, else the first unused slot of the
    // clock sweep with the used marks below it cleared, else every used mark
    // is cleared and slot 0 is taken.
    always_comb
    begin
        fill  = 1'b0;
        clear = 1'b0;
        if (!ctrl.any_hit)
        begin
            if (ctrl.any_inv)
            begin
                fill = !valid_reg && !flag_in.inv_seen;
            end
            else if (ctrl.any_unu)
            begin
                fill  = !used_reg && !flag_in.unu_seen;
                clear = used_reg && !flag_in.unu_seen;
            end
            else
            begin
                fill  = (IDX == 0);
                clear = (IDX != 0);
            end
        end
    end

    assign frame_out = frame_in | (my_hit ? frame_reg : '0);
    assign slot_out  = slot_in | ((my_hit || fill) ? IDX_W'(IDX) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            used_reg  <= 1'b0;
            dirty_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.capture)
            begin
                match_reg <= valid_reg && (page_reg == look_page);
            end
            if (ctrl.apply)
            begin
                if (fill)
                begin
                    valid_reg <= 1'b1;
                    used_reg  <= 1'b1;
                    dirty_reg <= ctrl.is_write;
                end
                else if (my_hit)
                begin
                    used_reg <= 1'b1;
                    if (ctrl.is_write)
                    begin
                        dirty_reg <= 1'b1;
                    end
                end
                else if (clear)
                begin
                    used_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.apply && fill)
        begin
            page_reg  <= fill_page;
            frame_reg <= fill_frame;
        end
    end

endmodule
